// ===== hw/rtl/ttb_pkg.sv =====
// Package for the triangle tangent/bitangent unit: widths, job type, helpers.
// No dependencies.
`default_nettype none
package ttb_pkg;
    localparam int CW = 16;          // coordinate width, Q8.8
    localparam int DW = CW + 1;      // delta width
    localparam int PW = 2 * DW + 1;  // product-difference width (det, numerators)
    localparam int NW = PW + 16;     // numerator scaled by 2^16
    localparam int QW = NW;          // quotient width
    localparam int QDEPTH = 2;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] delta_t;
    typedef logic signed [PW-1:0] prod_t;

    // one triangle job from front to back
    typedef struct packed {
        delta_t du1, dv1, du2, dv2;
        delta_t e1x, e1y, e1z, e2x, e2y, e2z;
    } job_t;

    // saturate a signed quotient magnitude to Q16.16
    function automatic logic [31:0] sat_q16(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        lim = neg ? QW'(33'h080000000) : QW'(33'h07fffffff);
        if (q > lim) return neg ? 32'h80000000 : 32'h7fffffff;
        return neg ? 32'(-q) : q[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ttb_front.sv =====
// Front end: holds the first two vertices and forms deltas on the third.
// Depends on ttb_pkg.
`default_nettype none
module ttb_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  ttb_pkg::coord_t       px, py, pz, tu, tv,
    input  wire                   last,
    output logic                  job_valid,
    input  wire                   job_ready,
    output ttb_pkg::job_t         job
);
    import ttb_pkg::*;
    typedef enum logic [1:0] {PH0, PH1, PH2} phase_t;
    phase_t phase_reg;
    coord_t a_reg [5];
    coord_t b_reg [5];
    logic job_valid_reg;
    job_t job_reg;
    logic acc;

    assign in_ready = !job_valid_reg || job_ready;
    assign acc = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    // phase tracking and job register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH0;
            job_valid_reg <= 1'b0;
        end else begin
            if (acc && phase_reg == PH2) job_valid_reg <= 1'b1;
            else if (job_ready) job_valid_reg <= 1'b0;
            if (acc) begin
                unique case (phase_reg)
                    PH1: phase_reg <= last ? PH0 : PH2;
                    PH2: phase_reg <= PH0;
                    default: phase_reg <= last ? PH0 : PH1;
                endcase
            end
        end
    end

    // vertex storage and delta forming
    always_ff @(posedge aclk) begin
        if (acc) begin
            unique case (phase_reg)
                PH1: begin
                    b_reg[0] <= px; b_reg[1] <= py; b_reg[2] <= pz;
                    b_reg[3] <= tu; b_reg[4] <= tv;
                end
                PH2: begin
                    job_reg.du1 <= DW'(b_reg[3]) - DW'(a_reg[3]);
                    job_reg.dv1 <= DW'(b_reg[4]) - DW'(a_reg[4]);
                    job_reg.du2 <= DW'(tu) - DW'(a_reg[3]);
                    job_reg.dv2 <= DW'(tv) - DW'(a_reg[4]);
                    job_reg.e1x <= DW'(b_reg[0]) - DW'(a_reg[0]);
                    job_reg.e1y <= DW'(b_reg[1]) - DW'(a_reg[1]);
                    job_reg.e1z <= DW'(b_reg[2]) - DW'(a_reg[2]);
                    job_reg.e2x <= DW'(px) - DW'(a_reg[0]);
                    job_reg.e2y <= DW'(py) - DW'(a_reg[1]);
                    job_reg.e2z <= DW'(pz) - DW'(a_reg[2]);
                end
                default: begin
                    a_reg[0] <= px; a_reg[1] <= py; a_reg[2] <= pz;
                    a_reg[3] <= tu; a_reg[4] <= tv;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ttb_queue.sv =====
// Short job queue between front and back.
// Depends on ttb_pkg.
`default_nettype none
module ttb_queue (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            wr_valid,
    output logic           wr_ready,
    input  ttb_pkg::job_t  wr_data,
    output logic           rd_valid,
    input  wire            rd_ready,
    output ttb_pkg::job_t  rd_data
);
    import ttb_pkg::*;
    localparam int AW = $clog2(QDEPTH);
    job_t mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ttb_back.sv =====
// Back end: numerators, then a radix-2 divider shared over six components.
// Depends on ttb_pkg.
`default_nettype none
module ttb_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 job_valid,
    output logic                job_ready,
    input  ttb_pkg::job_t       job,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [31:0]         res [6],
    output logic                degen
);
    import ttb_pkg::*;
    localparam int CBW = $clog2(QW + 1);
    typedef enum logic [2:0] {IDLE, MUL, NUM, DIV, RND, OUT} st_t;
    st_t st_reg;
    job_t j_reg;
    prod_t p0_reg, p1_reg;
    logic [2:0] mi_reg;      // multiply step
    prod_t num_reg [6];
    prod_t det_reg;
    logic [2:0] ci_reg;      // component index
    logic [CBW-1:0] bit_reg;
    logic [NW-1:0] n_reg;
    logic [PW:0] r_reg;
    logic [QW-1:0] q_reg;
    logic [PW-1:0] d_mag;
    logic neg;
    delta_t ma0, mb0, ma1, mb1;
    prod_t diff;
    logic [PW:0] r_sh;
    logic [NW-1:0] n_mag;

    assign job_ready = st_reg == IDLE;
    assign m_valid = st_reg == OUT;
    assign degen = det_reg == '0;
    assign d_mag = det_reg[PW-1] ? PW'(-det_reg) : det_reg;
    assign neg = num_reg[ci_reg][PW-1] ^ det_reg[PW-1];
    assign diff = p0_reg - p1_reg;
    assign r_sh = {r_reg[PW-1:0], n_reg[NW-1]};
    assign n_mag = num_reg[ci_reg][PW-1] ? NW'(-{num_reg[ci_reg], 16'h0})
                                         : NW'({num_reg[ci_reg], 16'h0});

    // operand select for the two multipliers of each step
    always_comb begin
        unique case (mi_reg)
            3'd0: begin ma0 = j_reg.du1; mb0 = j_reg.dv2; ma1 = j_reg.du2; mb1 = j_reg.dv1; end
            3'd1: begin ma0 = j_reg.dv2; mb0 = j_reg.e1x; ma1 = j_reg.dv1; mb1 = j_reg.e2x; end
            3'd2: begin ma0 = j_reg.dv2; mb0 = j_reg.e1y; ma1 = j_reg.dv1; mb1 = j_reg.e2y; end
            3'd3: begin ma0 = j_reg.dv2; mb0 = j_reg.e1z; ma1 = j_reg.dv1; mb1 = j_reg.e2z; end
            3'd4: begin ma0 = j_reg.du1; mb0 = j_reg.e2x; ma1 = j_reg.du2; mb1 = j_reg.e1x; end
            3'd5: begin ma0 = j_reg.du1; mb0 = j_reg.e2y; ma1 = j_reg.du2; mb1 = j_reg.e1y; end
            3'd6: begin ma0 = j_reg.du1; mb0 = j_reg.e2z; ma1 = j_reg.du2; mb1 = j_reg.e1z; end
            default: begin ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0; end
        endcase
    end

    // sequencer: products, differences, division and rounding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= IDLE;
        end else begin
            unique case (st_reg)
                IDLE: if (job_valid) begin
                    j_reg <= job;
                    mi_reg <= '0;
                    st_reg <= MUL;
                end
                MUL: begin
                    p0_reg <= PW'(ma0 * mb0);
                    p1_reg <= PW'(ma1 * mb1);
                    st_reg <= NUM;
                end
                NUM: begin
                    if (mi_reg == 3'd0) det_reg <= diff;
                    else num_reg[mi_reg - 3'd1] <= diff;
                    if (mi_reg == 3'd6) begin
                        ci_reg <= '0;
                        st_reg <= det_reg == '0 ? OUT : DIV;
                        bit_reg <= '0;
                    end else begin
                        mi_reg <= mi_reg + 3'd1;
                        st_reg <= MUL;
                    end
                end
                DIV: begin
                    if (bit_reg == '0) begin
                        n_reg <= n_mag;
                        r_reg <= '0;
                        q_reg <= '0;
                        bit_reg <= CBW'(QW);
                    end else begin
                        n_reg <= n_reg << 1;
                        if (r_sh >= {1'b0, d_mag}) begin
                            r_reg <= r_sh - {1'b0, d_mag};
                            q_reg <= {q_reg[QW-2:0], 1'b1};
                        end else begin
                            r_reg <= r_sh;
                            q_reg <= {q_reg[QW-2:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 1'b1;
                        if (bit_reg == CBW'(1)) st_reg <= RND;
                    end
                end
                RND: begin
                    num_reg[ci_reg] <= '0;
                    res[ci_reg] <= sat_q16(neg,
                        q_reg + QW'({r_reg, 1'b0} >= {2'b0, d_mag}));
                    bit_reg <= '0;
                    if (ci_reg == 3'd5) st_reg <= OUT;
                    else begin
                        ci_reg <= ci_reg + 3'd1;
                        st_reg <= DIV;
                    end
                end
                OUT: if (m_ready) st_reg <= IDLE;
                default: st_reg <= IDLE;
            endcase
            if (st_reg == NUM && mi_reg == 3'd6 && det_reg == '0) begin
                for (int k = 0; k < 6; k++) res[k] <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/triangle_tangent_bitangent_top.sv =====
// Triangle tangent/bitangent unit: front end, job queue, divider back end.
// Vertices are taken one per cycle while s_ready is high. Per job: accept, product
// steps for determinant and numerators, a rounded divider pass per component (none
// if the determinant is zero), then output; the next job starts once it is taken.
// Reset (aresetn low, synchronous) clears vertex phase, queue and sequencer.
// Depends on ttb_pkg, ttb_front, ttb_queue, ttb_back.
`default_nettype none
module triangle_tangent_bitangent_top (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  ttb_pkg::coord_t    s_pos_x,
    input  ttb_pkg::coord_t    s_pos_y,
    input  ttb_pkg::coord_t    s_pos_z,
    input  ttb_pkg::coord_t    s_tex_u,
    input  ttb_pkg::coord_t    s_tex_v,
    input  wire                s_last_of_mesh,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_tangent_x,
    output logic signed [31:0] m_tangent_y,
    output logic signed [31:0] m_tangent_z,
    output logic signed [31:0] m_bitangent_x,
    output logic signed [31:0] m_bitangent_y,
    output logic signed [31:0] m_bitangent_z,
    output logic               m_degenerate
);
    import ttb_pkg::*;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;
    logic [31:0] res [6];

    ttb_front u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .px(s_pos_x), .py(s_pos_y), .pz(s_pos_z), .tu(s_tex_u), .tv(s_tex_v),
        .last(s_last_of_mesh), .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    ttb_queue u_queue (
        .aclk, .aresetn, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
    );

    ttb_back u_back (
        .aclk, .aresetn, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .m_valid, .m_ready, .res, .degen(m_degenerate)
    );

    assign m_tangent_x = res[0];
    assign m_tangent_y = res[1];
    assign m_tangent_z = res[2];
    assign m_bitangent_x = res[3];
    assign m_bitangent_y = res[4];
    assign m_bitangent_z = res[5];
endmodule
`default_nettype wire
